/* rtl/slsw_pkg.sv */
// Shared types and constants for the schema level stack walker.
package slsw_pkg;

    localparam int LEVEL_W   = 6;
    localparam int KIDS_W    = 12;
    localparam int STATUS_W  = 3;
    localparam int COL_W     = 11;
    localparam int COL_IDX_W = 10;
    localparam int COL_MAX   = 2047;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 6'd63;
    localparam logic [COL_W-1:0]   COL_LIMIT_RESET  = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_ROOT     = 3'd0,
        ST_GROUP    = 3'd1,
        ST_LEAF     = 3'd2,
        ST_PAST     = 3'd3,
        ST_DEEP     = 3'd4,
        ST_UNTYPED  = 3'd5,
        ST_COLUMNS  = 3'd6
    } status_t;

    typedef struct packed {
        logic [KIDS_W-1:0]  left;
        logic [LEVEL_W-1:0] def;
        logic [LEVEL_W-1:0] rep;
        logic [LEVEL_W-1:0] ldef;
        logic [LEVEL_W-1:0] rdef;
    } frame_t;

    typedef struct packed {
        logic              is_root;
        logic [KIDS_W-1:0] child_count;
        logic              is_optional;
        logic              is_repeated;
        logic              typed;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [LEVEL_W-1:0]   max_def;
        logic [LEVEL_W-1:0]   max_rep;
        logic [LEVEL_W-1:0]   parent_def;
        logic [LEVEL_W-1:0]   rep_def;
        logic                 has_levels;
        logic [COL_IDX_W-1:0] column_index;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic more_pop;
    } sts_t;

endpackage

/* rtl/slsw_if.sv */
// Handshake channel interfaces for schema elements and column results.
interface slsw_in_if import slsw_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              is_root;
    logic [KIDS_W-1:0] child_count;
    logic              is_optional;
    logic              is_repeated;
    logic              typed;

    modport source (
        output valid, is_root, child_count, is_optional, is_repeated, typed,
        input  ready
    );
    modport sink (
        input  valid, is_root, child_count, is_optional, is_repeated, typed,
        output ready
    );
endinterface

interface slsw_out_if import slsw_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [LEVEL_W-1:0]   max_def;
    logic [LEVEL_W-1:0]   max_rep;
    logic [LEVEL_W-1:0]   parent_def;
    logic [LEVEL_W-1:0]   rep_def;
    logic                 has_levels;
    logic [COL_IDX_W-1:0] column_index;

    modport source (
        output valid, status, max_def, max_rep, parent_def, rep_def, has_levels,
               column_index,
        input  ready
    );
    modport sink (
        input  valid, status, max_def, max_rep, parent_def, rep_def, has_levels,
               column_index,
        output ready
    );
endinterface

/* rtl/slsw_ctrl.sv */
// Sequencing state machine for the schema level stack walker.
module slsw_ctrl import slsw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_PWAIT = 4'b0100,
        S_POP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = sts.more_pop ? S_PWAIT : S_IDLE;
                end
            end
            S_PWAIT:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = sts.more_pop ? S_PWAIT : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/slsw_dp.sv */
// Datapath with the group stack memory, level arithmetic and result register.
module slsw_dp import slsw_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  item_t              item_in,
    input  logic               cfg_we,
    input  logic [COL_W-1:0]   cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output result_t            result
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W   = $clog2(STACK_DEPTH);
    localparam int LIM_CAP = (MAX_COLUMNS < COL_MAX) ? MAX_COLUMNS : COL_MAX;

    localparam logic [COL_W-1:0]   LimCapW  = COL_W'(LIM_CAP);
    localparam logic [DEPTH_W-1:0] DepthTop = DEPTH_W'(STACK_DEPTH);

    frame_t stack_mem [STACK_DEPTH];
    frame_t rd_frame_reg;
    frame_t wr_frame;
    logic   wr_en;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] top_ptr;

    item_t              item_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [COL_W-1:0]   seen_reg, seen_next;
    logic               failed_reg, failed_next;
    logic [COL_W-1:0]   limit_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;

    logic [DEPTH_W-1:0] depth_dec;
    logic               kids_nz, rep_f, opt_f;
    logic [LEVEL_W:0]   def_sum, rep_sum;
    logic [LEVEL_W-1:0] new_def, new_rep, new_ldef, new_rdef;
    logic [KIDS_W-1:0]  left_dec;
    logic               left_zero;
    logic [COL_W-1:0]   limit;
    logic               pop_now;
    logic               fail_now;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign top_ptr   = depth_dec[PTR_W-1:0];
    assign kids_nz   = |item_reg.child_count;
    assign rep_f     = item_reg.is_repeated;
    assign opt_f     = item_reg.is_optional & ~item_reg.is_repeated;
    assign def_sum   = {1'b0, rd_frame_reg.def} + (LEVEL_W+1)'(opt_f) + (LEVEL_W+1)'(rep_f);
    assign rep_sum   = {1'b0, rd_frame_reg.rep} + (LEVEL_W+1)'(rep_f);
    assign new_def   = def_sum[LEVEL_W] ? LEVEL_MAX : def_sum[LEVEL_W-1:0];
    assign new_rep   = rep_sum[LEVEL_W] ? LEVEL_MAX : rep_sum[LEVEL_W-1:0];
    assign new_ldef  = rep_f ? rd_frame_reg.def : rd_frame_reg.ldef;
    assign new_rdef  = rep_f ? new_def : rd_frame_reg.rdef;
    assign left_dec  = rd_frame_reg.left - KIDS_W'(1);
    assign left_zero = (left_dec == '0);
    assign limit     = (limit_reg < LimCapW) ? limit_reg : LimCapW;

    always_comb
    begin
        depth_next  = depth_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        res_next    = '0;
        wr_en       = 1'b0;
        wr_ptr      = top_ptr;
        wr_frame    = rd_frame_reg;
        pop_now     = cmd.pop;
        fail_now    = 1'b0;
        sts.out_busy = out_valid_reg & ~out_ready;
        sts.more_pop = 1'b0;

        if (cmd.exec)
        begin
            priority if (item_reg.is_root)
            begin
                failed_next     = 1'b0;
                seen_next       = '0;
                depth_next      = kids_nz ? DEPTH_W'(1) : '0;
                res_next.status = ST_ROOT;
                if (kids_nz)
                begin
                    wr_en         = 1'b1;
                    wr_ptr        = '0;
                    wr_frame      = '0;
                    wr_frame.left = item_reg.child_count;
                end
            end
            else if (failed_reg || depth_reg == '0)
            begin
                fail_now        = 1'b1;
                res_next.status = ST_PAST;
            end
            else if (kids_nz)
            begin
                if (depth_reg == DepthTop)
                begin
                    fail_now        = 1'b1;
                    res_next.status = ST_DEEP;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_ptr        = depth_reg[PTR_W-1:0];
                    wr_frame.left = item_reg.child_count;
                    wr_frame.def  = new_def;
                    wr_frame.rep  = new_rep;
                    wr_frame.ldef = new_ldef;
                    wr_frame.rdef = new_rdef;
                    depth_next    = depth_reg + DEPTH_W'(1);
                    res_next.status = ST_GROUP;
                end
            end
            else if (!item_reg.typed)
            begin
                fail_now        = 1'b1;
                res_next.status = ST_UNTYPED;
            end
            else if (seen_reg >= limit)
            begin
                fail_now        = 1'b1;
                res_next.status = ST_COLUMNS;
            end
            else
            begin
                res_next.status       = ST_LEAF;
                res_next.max_def      = new_def;
                res_next.max_rep      = new_rep;
                res_next.parent_def   = new_ldef;
                res_next.rep_def      = new_rdef;
                res_next.has_levels   = (new_def != '0);
                res_next.column_index = seen_reg[COL_IDX_W-1:0];
                seen_next             = seen_reg + COL_W'(1);
                pop_now               = 1'b1;
            end
        end

        if (fail_now)
        begin
            failed_next = 1'b1;
            depth_next  = '0;
        end

        if (pop_now)
        begin
            wr_en         = 1'b1;
            wr_ptr        = top_ptr;
            wr_frame      = rd_frame_reg;
            wr_frame.left = left_dec;
            if (left_zero)
            begin
                depth_next   = depth_dec;
                sts.more_pop = (depth_dec != '0);
            end
        end
    end

    assign out_valid_next = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_ptr] <= wr_frame;
        end
        rd_frame_reg <= stack_mem[top_ptr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            seen_reg      <= '0;
            failed_reg    <= 1'b0;
            limit_reg     <= COL_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

/* rtl/schema_level_stack_walker_top.sv */
// Top level of the schema level stack walker.
//
// Schema elements arrive in depth-first order on in_ch, one word per element,
// and one result word leaves on out_ch for every element. A word is taken on a
// clock edge where valid and ready are both high. The user must write the column
// limit through cfg_we and cfg_data while idle; the block does not enforce it.
// An element's result reaches the output register when the element is
// evaluated: the top frame is read from the stack memory at the accepting
// edge and evaluated in the following cycle, unless the output register still
// holds a word that was not taken. For every group that a leaf closes while an
// outer group remains open, a further pop follows, and every further pop waits
// for the registered read of the new top frame. The next element is accepted
// once this pop sequence has finished.
// The output register holds its word while out_ch.ready is low; the block
// still accepts one more element, which waits for the register before it
// completes. Reset empties the stack, clears the column count and the error
// flag, sets the column limit to 1024 and drops out_ch.valid.
module schema_level_stack_walker_top import slsw_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    slsw_in_if.sink          in_ch,
    slsw_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [COL_W-1:0] cfg_data
);

    cmd_t    cmd;
    sts_t    sts;
    item_t   item_in;
    result_t result;
    logic    in_ready;
    logic    out_valid;

    assign item_in.is_root      = in_ch.is_root;
    assign item_in.child_count  = in_ch.child_count;
    assign item_in.is_optional  = in_ch.is_optional;
    assign item_in.is_repeated  = in_ch.is_repeated;
    assign item_in.typed        = in_ch.typed;
    assign in_ch.ready          = in_ready;

    slsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slsw_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item_in   (item_in),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign out_ch.valid        = out_valid;
    assign out_ch.status       = result.status;
    assign out_ch.max_def      = result.max_def;
    assign out_ch.max_rep      = result.max_rep;
    assign out_ch.parent_def   = result.parent_def;
    assign out_ch.rep_def      = result.rep_def;
    assign out_ch.has_levels   = result.has_levels;
    assign out_ch.column_index = result.column_index;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("element accepted while the previous one was in progress");

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(out_ch.valid && !out_ch.ready))
        else $error("result overwrote a word that was not yet taken");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> !cmd.pop)
        else $error("pop issued before the new top frame was read");

    a_non_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_LEAF |->
            out_ch.max_def == '0 && out_ch.column_index == '0 && !out_ch.has_levels)
        else $error("non-leaf result carries leaf levels");

endmodule
